// File: hw/rtl/nfa_epsilon_closure_matcher_macros.svh
// Assertion macros shared by the checker
`ifndef NFA_EPSILON_CLOSURE_MATCHER_MACROS_SVH
`define NFA_EPSILON_CLOSURE_MATCHER_MACROS_SVH
// assert that a implies b in the next cycle
`define NEC_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle check failed");
// assert that a implies b in the same cycle
`define NEC_ASSERT_NOW(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("same-cycle check failed");
`endif

// File: hw/rtl/nec_pkg.sv
// ----------------------------------------------------------------------------
// nec_pkg
// Types and constants of the NFA matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package nec_pkg;
   localparam int NUM_STATES  = 16;
   localparam int SYMBOL_BITS = 8;
   localparam int STATE_BITS  = $clog2(NUM_STATES);
   localparam int SYM_COUNT   = 1 << SYMBOL_BITS;
   localparam int TABLE_DEPTH = NUM_STATES * SYM_COUNT;
   localparam int TABLE_ABITS = $clog2(TABLE_DEPTH);
   localparam int ENTRY_BITS  = 5;

   localparam logic [1:0] MODE_WRITE   = 2'd0;
   localparam logic [1:0] MODE_EPSILON = 2'd1;
   localparam logic [1:0] MODE_RESTART = 2'd2;
   localparam logic [1:0] MODE_CONSUME = 2'd3;

   localparam logic [0:0] REG_INITIAL = 1'b0;
   localparam logic [0:0] REG_FINAL   = 1'b1;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] symbol;
      logic [3:0] from_state;
      logic [3:0] to_state;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        dead;
      logic [15:0] active_set;
   } rsp_type;

   typedef struct packed {
      logic load_req;
      logic clear_start;
      logic clear_step;
      logic write_entry;
      logic write_eps;
      logic load_init;
      logic move_start;
      logic move_step;
      logic move_commit;
      logic close_step;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       clear_last;
      logic       move_last;
      logic       close_done;
   } sts_type;
endpackage

// File: hw/rtl/nec_ram.sv
// ----------------------------------------------------------------------------
// nec_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module nec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end
   assign rdata = rdata_ff;
endmodule

// File: hw/rtl/nec_datapath.sv
// ----------------------------------------------------------------------------
// nec_datapath
// Transition table, epsilon masks, active set and closure iteration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module nec_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  nec_pkg::cmd_type        cmd,
   output nec_pkg::sts_type        sts,
   input  nec_pkg::req_type        req,
   input  logic [3:0]              init_state,
   output logic [15:0]             active_set
);
   import nec_pkg::*;

   req_type                 req_ff;
   logic [TABLE_ABITS-1:0]  cnt_ff, cnt_in;
   logic [NUM_STATES-1:0]   eps_ff [NUM_STATES];
   logic [NUM_STATES-1:0]   act_ff, act_in;
   logic [NUM_STATES-1:0]   next_ff, next_in;
   logic                    rd_valid_ff;
   logic [NUM_STATES-1:0]   grow;
   logic                    ram_we;
   logic [TABLE_ABITS-1:0]  ram_addr;
   logic [ENTRY_BITS-1:0]   ram_wdata, ram_rdata;
   logic [STATE_BITS-1:0]   cur_state;
   logic                    ok_pair;

   assign cur_state = cnt_ff[STATE_BITS-1:0];
   assign ok_pair = ({28'd0, req_ff.from_state} < NUM_STATES) &&
                    ({28'd0, req_ff.to_state} < NUM_STATES);

   always_comb begin
      ram_we = 1'b0;
      ram_wdata = '0;
      ram_addr = {cur_state, req_ff.symbol[SYMBOL_BITS-1:0]};
      if (cmd.clear_step) begin
         ram_we = 1'b1;
         ram_addr = cnt_ff;
      end else if (cmd.write_entry) begin
         ram_we = ok_pair;
         ram_addr = {req_ff.from_state[STATE_BITS-1:0], req_ff.symbol[SYMBOL_BITS-1:0]};
         ram_wdata = {1'b1, req_ff.to_state};
      end
   end

   nec_ram #(.WIDTH(ENTRY_BITS), .DEPTH(TABLE_DEPTH)) u_table (
      .clock(clock), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   always_comb begin
      grow = act_ff;
      for (int s = 0; s < NUM_STATES; s++) begin
         if (act_ff[s]) grow = grow | eps_ff[s];
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.clear_start || cmd.move_start) cnt_in = '0;
      else if (cmd.clear_step || cmd.move_step) cnt_in = cnt_ff + 1'b1;
      next_in = next_ff;
      if (cmd.move_start) next_in = '0;
      else if (rd_valid_ff && ram_rdata[ENTRY_BITS-1] &&
               ({28'd0, ram_rdata[3:0]} < NUM_STATES))
         next_in = next_ff | (NUM_STATES'(1) << ram_rdata[STATE_BITS-1:0]);
      act_in = act_ff;
      if (cmd.load_init)
         act_in = ({28'd0, init_state} < NUM_STATES) ?
                  (NUM_STATES'(1) << init_state[STATE_BITS-1:0]) : '0;
      else if (cmd.move_commit) act_in = next_ff;
      else if (cmd.close_step) act_in = grow;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req;
      if (reset) begin
         cnt_ff <= '0;
         act_ff <= NUM_STATES'(1);
         rd_valid_ff <= 1'b0;
         next_ff <= '0;
         for (int s = 0; s < NUM_STATES; s++) eps_ff[s] <= '0;
      end else begin
         cnt_ff <= cnt_in;
         act_ff <= act_in;
         next_ff <= next_in;
         rd_valid_ff <= cmd.move_step && act_ff[cur_state];
         if (cmd.write_eps && ok_pair)
            eps_ff[req_ff.from_state[STATE_BITS-1:0]] <=
               eps_ff[req_ff.from_state[STATE_BITS-1:0]] |
               (NUM_STATES'(1) << req_ff.to_state[STATE_BITS-1:0]);
      end
   end

   assign sts.mode       = req_ff.mode;
   assign sts.clear_last = &cnt_ff;
   assign sts.move_last  = (cur_state == STATE_BITS'(NUM_STATES - 1));
   assign sts.close_done = (grow == act_ff);
   assign active_set     = 16'(act_ff);
endmodule

// File: hw/rtl/nec_control.sv
// ----------------------------------------------------------------------------
// nec_control
// Sequencer of the NFA matcher: table clear, writes, move and closure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module nec_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  nec_pkg::sts_type sts,
   output nec_pkg::cmd_type cmd
);
   import nec_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_MOVE  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_CLOSE = 3'd5;
   localparam logic [2:0] ST_RESP  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       first_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cmd.load_req = req_valid;
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            unique case (sts.mode)
               MODE_WRITE: begin
                  cmd.write_entry = 1'b1;
                  state_in = ST_RESP;
               end
               MODE_EPSILON: begin
                  cmd.write_eps = 1'b1;
                  state_in = ST_RESP;
               end
               MODE_RESTART: begin
                  cmd.load_init = 1'b1;
                  state_in = ST_CLOSE;
               end
               MODE_CONSUME: begin
                  cmd.move_start = 1'b1;
                  state_in = ST_MOVE;
               end
               default: state_in = ST_RESP;
            endcase
         end
         ST_MOVE: begin
            cmd.move_step = 1'b1;
            if (sts.move_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!first_ff) begin
               cmd.move_commit = 1'b1;
               state_in = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            cmd.close_step = 1'b1;
            if (sts.close_done) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         first_ff <= (state_ff == ST_MOVE) && (state_in == ST_DRAIN);
      end
   end
endmodule

// File: hw/rtl/nfa_epsilon_closure_matcher.sv
// ----------------------------------------------------------------------------
// nfa_epsilon_closure_matcher
// NFA simulation over a byte stream with bit-vector active set.
// ----------------------------------------------------------------------------
// After reset the transition table is cleared, one entry a cycle, all 4096
// entries, before the first request is taken. A write or epsilon request
// passes the execute and response states; a restart loads the initial state
// and runs closure rounds until a round finds nothing new; a consume first
// scans all 16 states through the single table port, drains the registered
// read and commits the next set, then runs the same closure loop.
// A stalled response holds the matcher in its response state until taken.
`timescale 1ns / 1ps
module nfa_epsilon_closure_matcher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  nec_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output nec_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:2]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import nec_pkg::*;

   cmd_type     cmd;
   sts_type     sts;
   logic [3:0]  init_ff;
   logic [15:0] final_ff;
   logic [15:0] act;

   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= '0;
         final_ff <= '0;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[2])
            REG_INITIAL: init_ff <= pwdata[3:0];
            REG_FINAL:   final_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end
   assign prdata = paddr[2] ? {16'd0, final_ff} : {28'd0, init_ff};

   nec_control u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .sts(sts), .cmd(cmd)
   );
   nec_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .req(req_data),
      .init_state(init_ff), .active_set(act)
   );

   assign rsp_data.accepted   = |(act & final_ff);
   assign rsp_data.dead       = ~|act;
   assign rsp_data.active_set = act;
endmodule

// File: hw/rtl/nec_checker.sv
// ----------------------------------------------------------------------------
// nec_checker
// Port-level checks of the NFA matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nfa_epsilon_closure_matcher_macros.svh"
module nec_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input nec_pkg::rsp_type rsp_data
);
   `NEC_ASSERT_NEXT(a_one_out, clock, reset, req_valid && req_ready, !req_ready)
   `NEC_ASSERT_NOW(a_excl, clock, reset, rsp_valid, !req_ready)
   `NEC_ASSERT_NOW(a_dead, clock, reset, rsp_valid, rsp_data.dead == (rsp_data.active_set == 16'd0))
   `NEC_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
endmodule

bind nfa_epsilon_closure_matcher nec_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);

// File: bench/tb_nfa_epsilon_closure_matcher.sv
// ----------------------------------------------------------------------------
// tb_nfa_epsilon_closure_matcher
// Drives transition writes, epsilon edges, restarts and consumed symbols
// through the request channel with random gaps on both sides, predicts the
// active set after every request and compares each response field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_nfa_epsilon_closure_matcher;
   import nec_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:2]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   nfa_epsilon_closure_matcher dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   typedef struct {
      req_type req;
      logic    known;
      rsp_type rsp;
   } row_type;

   logic [4:0]  nfa_table [0:4095];
   logic [15:0] nfa_eps [0:15];
   logic [15:0] nfa_active;
   logic [3:0]  nfa_init;
   logic [15:0] nfa_final;
   rsp_type     pending_rsp [$];
   row_type     rows [$];
   int          errors;
   int          accepted_count;
   int          consume_count;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("FAIL");
      $finish;
   end

   function automatic logic [15:0] closure_set(logic [15:0] set);
      logic [15:0] prev;
      do begin
         prev = set;
         for (int s = 0; s < 16; s++)
            if (set[s]) set = set | nfa_eps[s];
      end while (set != prev);
      return set;
   endfunction

   function automatic rsp_type nfa_predict(req_type r);
      rsp_type o;
      logic [15:0] nxt;
      logic [4:0]  e;
      case (r.mode)
         MODE_WRITE: nfa_table[{r.from_state, r.symbol}] = {1'b1, r.to_state};
         MODE_EPSILON: nfa_eps[r.from_state][r.to_state] = 1'b1;
         MODE_RESTART: nfa_active = closure_set(16'(1) << nfa_init);
         default: begin
            nxt = '0;
            for (int s = 0; s < 16; s++)
               if (nfa_active[s]) begin
                  e = nfa_table[{s[3:0], r.symbol}];
                  if (e[4]) nxt[e[3:0]] = 1'b1;
               end
            nfa_active = (nxt != 0) ? closure_set(nxt) : '0;
         end
      endcase
      o.accepted = |(nfa_active & nfa_final);
      o.dead = (nfa_active == 0);
      o.active_set = nfa_active;
      return o;
   endfunction

   task automatic add_row(req_type r, logic known, rsp_type x);
      row_type rw;
      rw.req = r;
      rw.known = known;
      rw.rsp = x;
      rows.insert(rows.size(), rw);
   endtask

   task automatic csr_write(logic [2:2] addr, logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (addr == REG_INITIAL) nfa_init = data[3:0];
      else nfa_final = data[15:0];
   endtask

   task automatic send_request(req_type r);
      int gap;
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      pending_rsp.insert(pending_rsp.size(), nfa_predict(r));
      if (r.mode == MODE_CONSUME) consume_count++;
   endtask

   task automatic drain;
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
   endtask

   function automatic req_type mk(logic [1:0] m, logic [7:0] s, logic [3:0] f, logic [3:0] t);
      req_type r;
      r.mode = m; r.symbol = s; r.from_state = f; r.to_state = t;
      return r;
   endfunction

   function automatic req_type random_req(int bias);
      req_type r;
      int pick;
      pick = $urandom_range(0, 99);
      r = mk(MODE_CONSUME, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
         4'($urandom_range(0, 15)));
      if (bias != 0) r.symbol = 8'($urandom_range(0, 3) * 85);
      if (pick < 20) r.mode = MODE_WRITE;
      else if (pick < 30) r.mode = MODE_EPSILON;
      else if (pick < 42) r.mode = MODE_RESTART;
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response with nothing outstanding");
            errors++;
         end else begin
            rsp_type x;
            x = pending_rsp.pop_front();
            accepted_count++;
            if (rsp_data.accepted !== x.accepted) begin
               $error("accepted expected %0b actual %0b", x.accepted, rsp_data.accepted);
               errors++;
            end
            if (rsp_data.dead !== x.dead) begin
               $error("dead expected %0b actual %0b", x.dead, rsp_data.dead);
               errors++;
            end
            if (rsp_data.active_set !== x.active_set) begin
               $error("active_set expected %h actual %h", x.active_set, rsp_data.active_set);
               errors++;
            end
         end
      end
   end

   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
         rsp_ready <= 1'b0;
         repeat (stall) @(posedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin
      row_type rw;
      rsp_type exp_rsp;
      errors = 0; accepted_count = 0; consume_count = 0;
      reset = 1'b1; req_valid = 1'b0; req_data = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      for (int i = 0; i < 4096; i++) nfa_table[i] = '0;
      for (int i = 0; i < 16; i++) nfa_eps[i] = '0;
      nfa_active = 16'h0001; nfa_init = '0; nfa_final = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // after reset, extremes, and hand-built automaton
      add_row(mk(MODE_WRITE, 8'h00, 4'h0, 4'h0), 1'b1, '{1'b0, 1'b0, 16'h0001});
      add_row(mk(MODE_CONSUME, 8'hFF, 4'h0, 4'h0), 1'b1, '{1'b0, 1'b1, 16'h0000});
      add_row(mk(MODE_CONSUME, 8'h00, 4'hF, 4'hF), 1'b1, '{1'b0, 1'b1, 16'h0000});
      add_row(mk(MODE_RESTART, 8'h00, 4'h0, 4'h0), 1'b1, '{1'b0, 1'b0, 16'h0001});
      add_row(mk(MODE_CONSUME, 8'h00, 4'h0, 4'h0), 1'b1, '{1'b0, 1'b0, 16'h0001});
      add_row(mk(MODE_EPSILON, 8'hFF, 4'h0, 4'hF), 1'b0, '0);
      add_row(mk(MODE_EPSILON, 8'h00, 4'h0, 4'hF), 1'b0, '0);
      add_row(mk(MODE_EPSILON, 8'h00, 4'hF, 4'h7), 1'b0, '0);
      add_row(mk(MODE_RESTART, 8'h00, 4'h0, 4'h0), 1'b0, '0);
      add_row(mk(MODE_WRITE, 8'hFF, 4'h7, 4'h3), 1'b0, '0);
      add_row(mk(MODE_WRITE, 8'hFF, 4'h7, 4'h9), 1'b0, '0);
      add_row(mk(MODE_CONSUME, 8'hFF, 4'h0, 4'h0), 1'b0, '0);
      add_row(mk(MODE_CONSUME, 8'hFF, 4'h0, 4'h0), 1'b0, '0);
      add_row(mk(MODE_CONSUME, 8'h55, 4'h0, 4'h0), 1'b0, '0);
      add_row(mk(MODE_RESTART, 8'hAA, 4'hA, 4'h5), 1'b0, '0);
      foreach (rows[i]) begin
         rw = rows[i];
         if (rw.known) begin
            exp_rsp = nfa_predict(rw.req);
            if (exp_rsp != rw.rsp) begin
               $error("table row %0d disagrees with predictor", i);
               errors++;
            end
            nfa_active = (i == 0) ? 16'h0001 : nfa_active;
         end
      end
      // reset predictor state to its after-reset values, then replay the table
      for (int i = 0; i < 4096; i++) nfa_table[i] = '0;
      for (int i = 0; i < 16; i++) nfa_eps[i] = '0;
      nfa_active = 16'h0001;
      foreach (rows[i]) send_request(rows[i].req);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin csr_write(REG_INITIAL, 32'hF); csr_write(REG_FINAL, 32'hFFFF); end
            1: begin csr_write(REG_INITIAL, 32'h0); csr_write(REG_FINAL, 32'h0); end
            2: begin csr_write(REG_INITIAL, 32'hFFFF_FFF5); csr_write(REG_FINAL, 32'hFFFF_8001); end
            default: begin
               csr_write(REG_INITIAL, $urandom);
               csr_write(REG_FINAL, $urandom);
            end
         endcase
         send_request(mk(MODE_RESTART, 8'($urandom), 4'($urandom), 4'($urandom)));
         for (int n = 0; n < 100; n++) send_request(random_req(phase % 2));
         drain();
      end

      $display("Covered %0d responses, %0d consumed symbols, six register settings.",
         accepted_count, consume_count);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
